@@ hw/rtl/skcf_pkg.sv @@
// ----------------------------------------------------------------------------
// skcf_pkg
// Shared constants for the scalar Kalman channel filter: register indexes,
// reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package skcf_pkg;

   // Configuration register indexes
   localparam logic [7:0] CSR_CHANNELS_IN_USE = 8'd0;
   localparam logic [7:0] CSR_DEFAULT_NOISE   = 8'd1;

   // Register reset values
   localparam logic [3:0]  CHANNELS_IN_USE_RESET = 4'd8;
   localparam logic [31:0] DEFAULT_NOISE_RESET   = 32'd6554;

   // Fixed point: covariance and gain are Q1.31, 1.0 = 2^31
   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

   // Saturation bounds of a signed Q16.16 value at sum width
   localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] SAT_MIN = -36'sh0_8000_0000;

   // Quotient bits produced by the gain divider, one per cycle
   localparam int unsigned DIV_STEPS = 32;

   // Item kinds
   localparam logic FUNC_UPDATE  = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

endpackage

@@ hw/rtl/scalar_kalman_channel_filter.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_channel_filter
// Flow: an update item goes through read, setup, 32 divide steps (skipped when
//   P+R is zero), two multiplies, write-back and reply; a restart or rejected
//   item goes straight from acceptance to reply.
// Throughput: one item at a time, set by the bit-serial gain divider; the
//   next item is taken only after the last result enters the output slot.
// Reset: synchronous, active high; clears configuration registers, state,
//   primed mask and result valid.
// Bank of per-channel scalar Kalman filters. Each update computes
// gain = P/(P+R) with a restoring divider, then est += gain*(z-est) and
// P = (1-gain)*P on one shared multiplier, and stores est and P per channel.
// ----------------------------------------------------------------------------
module scalar_kalman_channel_filter #(
   parameter int CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,

   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // channel[2:0], reading[34:3], noise[66:35], zero
   input  logic [1:0]  req_tuser,   // func[0], use_default_noise[1]

   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // estimate[31:0], out_channel[34:32], zero
   output logic        rsp_tuser,   // ok[0]

   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(skcf_pkg::DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SETUP,
      ST_DIV,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_WRITE,
      ST_REPLY
   } state_type;

   // Unpack request fields
   logic        req_func;
   logic [2:0]  req_channel;
   logic [31:0] req_reading;
   logic [31:0] req_noise;
   logic        req_use_default_noise;

   assign req_channel           = req_tdata[2:0];
   assign req_reading           = req_tdata[34:3];
   assign req_noise             = req_tdata[66:35];
   assign req_func              = req_tuser[0];
   assign req_use_default_noise = req_tuser[1];

   // Configuration registers
   logic [3:0]  channels_in_use_ff;
   logic [31:0] default_noise_ff;

   // Control and datapath registers
   state_type            state_ff, state_in;
   logic [CHANNELS-1:0]  primed_ff, primed_in;
   logic [2:0]           ch_ff, ch_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [31:0]          z_ff, z_in;
   logic [31:0]          r_ff, r_in;
   logic [31:0]          p_ff, p_in;
   logic [31:0]          est_ff, est_in;
   logic [47:0]          denom_ff, denom_in;
   logic [47:0]          rem_ff, rem_in;
   logic [31:0]          numbits_ff, numbits_in;
   logic [31:0]          gain_ff, gain_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic signed [65:0]   prod_ff, prod_in;
   logic [31:0]          newest_ff, newest_in;
   logic                 ok_ff, ok_in;

   // Result registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_est_ff, rsp_est_in;
   logic [2:0]           rsp_ch_ff, rsp_ch_in;
   logic                 rsp_ok_ff, rsp_ok_in;

   // Per-channel stores and their registered read data
   logic [31:0] est_mem [CHANNELS];
   logic [31:0] cov_mem [CHANNELS];
   logic [31:0] est_rd_ff;
   logic [31:0] cov_rd_ff;

   // Combinational helpers
   logic                req_accept;
   logic                rejected;
   logic [31:0]         p_sel;
   logic [31:0]         est_sel;
   logic [47:0]         denom_sel;
   logic [48:0]         trial;
   logic                qbit;
   logic [31:0]         quo_next;
   logic signed [32:0]  mul_a;
   logic signed [32:0]  mul_b;
   logic signed [65:0]  mul_p;
   logic signed [34:0]  step;
   logic signed [35:0]  sum;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ch_ff, rsp_est_ff};
   assign rsp_tuser  = rsp_ok_ff;

   assign rejected = ({1'b0, req_channel} >= channels_in_use_ff)
                     || ({29'd0, req_channel} >= 32'(CHANNELS));

   // Shared multiplier
   assign mul_p = mul_a * mul_b;

   // Next-state and datapath logic
   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      z_in         = z_ff;
      r_in         = r_ff;
      p_in         = p_ff;
      est_in       = est_ff;
      denom_in     = denom_ff;
      rem_in       = rem_ff;
      numbits_in   = numbits_ff;
      gain_in      = gain_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      newest_in    = newest_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_ok_in    = rsp_ok_ff;

      p_sel     = primed_ff[idx_ff] ? cov_rd_ff : skcf_pkg::ONE_Q31;
      est_sel   = primed_ff[idx_ff] ? est_rd_ff : 32'd0;
      denom_sel = 48'(p_sel) + {1'b0, r_ff, 15'd0};
      trial     = {rem_ff, numbits_ff[31]};
      qbit      = (trial >= {1'b0, denom_ff});
      quo_next  = {gain_ff[30:0], qbit};
      mul_a     = '0;
      mul_b     = '0;
      step      = prod_ff[65:31];
      sum       = 36'($signed(est_ff)) + 36'(step);

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ch_in  = req_channel;
               idx_in = IDX_W'(req_channel);
               z_in   = req_reading;
               r_in   = req_use_default_noise ? default_noise_ff : req_noise;
               if (req_func == skcf_pkg::FUNC_RESTART) begin
                  primed_in = '0;
                  newest_in = 32'd0;
                  ok_in     = 1'b1;
                  state_in  = ST_REPLY;
               end else if (rejected) begin
                  newest_in = 32'd0;
                  ok_in     = 1'b0;
                  state_in  = ST_REPLY;
               end else begin
                  state_in  = ST_LOAD;
               end
            end
         end

         // Store read of the channel is in flight
         ST_LOAD: begin
            state_in = ST_SETUP;
         end

         // Pick start values and prime the divider
         ST_SETUP: begin
            p_in       = p_sel;
            est_in     = est_sel;
            denom_in   = denom_sel;
            rem_in     = {17'd0, p_sel[31:1]};
            numbits_in = {p_sel[0], 31'd0};
            gain_in    = 32'd0;
            cnt_in     = '0;
            if (denom_sel == 48'd0) begin
               state_in = ST_MUL_EST;
            end else begin
               state_in = ST_DIV;
            end
         end

         // One restoring divide step a cycle
         ST_DIV: begin
            rem_in     = qbit ? 48'(trial - {1'b0, denom_ff}) : trial[47:0];
            numbits_in = {numbits_ff[30:0], 1'b0};
            gain_in    = quo_next;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(skcf_pkg::DIV_STEPS - 1)) begin
               if (quo_next > skcf_pkg::ONE_Q31) begin
                  gain_in = skcf_pkg::ONE_Q31;
               end
               state_in = ST_MUL_EST;
            end
         end

         // gain * (z - est)
         ST_MUL_EST: begin
            mul_a    = {1'b0, gain_ff};
            mul_b    = 33'($signed(z_ff)) - 33'($signed(est_ff));
            prod_in  = mul_p;
            state_in = ST_MUL_COV;
         end

         // Saturate the new estimate, then (1 - gain) * P
         ST_MUL_COV: begin
            if (sum > skcf_pkg::SAT_MAX) begin
               newest_in = skcf_pkg::SAT_MAX[31:0];
            end else if (sum < skcf_pkg::SAT_MIN) begin
               newest_in = skcf_pkg::SAT_MIN[31:0];
            end else begin
               newest_in = sum[31:0];
            end
            mul_a    = {1'b0, skcf_pkg::ONE_Q31 - gain_ff};
            mul_b    = {1'b0, p_ff};
            prod_in  = mul_p;
            state_in = ST_WRITE;
         end

         // Stores are written this cycle
         ST_WRITE: begin
            primed_in[idx_ff] = 1'b1;
            ok_in             = 1'b1;
            state_in          = ST_REPLY;
         end

         // Hand over the result once the output slot is free
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_est_in   = newest_ff;
               rsp_ch_in    = ch_ff;
               rsp_ok_in    = ok_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         primed_ff          <= '0;
         rsp_valid_ff       <= 1'b0;
         channels_in_use_ff <= skcf_pkg::CHANNELS_IN_USE_RESET;
         default_noise_ff   <= skcf_pkg::DEFAULT_NOISE_RESET;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               skcf_pkg::CSR_CHANNELS_IN_USE: channels_in_use_ff <= csr_data[3:0];
               skcf_pkg::CSR_DEFAULT_NOISE:   default_noise_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Datapath payload, no reset
   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      idx_ff     <= idx_in;
      z_ff       <= z_in;
      r_ff       <= r_in;
      p_ff       <= p_in;
      est_ff     <= est_in;
      denom_ff   <= denom_in;
      rem_ff     <= rem_in;
      numbits_ff <= numbits_in;
      gain_ff    <= gain_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      newest_ff  <= newest_in;
      ok_ff      <= ok_in;
      rsp_est_ff <= rsp_est_in;
      rsp_ch_ff  <= rsp_ch_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   // Channel stores: write back in ST_WRITE, registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         est_mem[idx_ff] <= newest_ff;
         cov_mem[idx_ff] <= prod_ff[62:31];
      end
      est_rd_ff <= est_mem[idx_ff];
      cov_rd_ff <= cov_mem[idx_ff];
   end

endmodule
